// File: rtl/core/cfv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfv_pkg
// Shared types, character codes and the hex digit decoder for the checksum
// frame validator.
// ----------------------------------------------------------------------------
package cfv_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned NIBBLE_W = 4;

    // Character codes that the line format relies on.
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_0      = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9      = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UA     = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UF     = 8'h46;
    localparam logic [BYTE_W-1:0] CH_LA     = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h66;
    localparam logic [BYTE_W-1:0] HEX_TEN   = 8'd10;

    // Position within the line.
    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_PAYLOAD = 3'd1,
        PH_HEX1    = 3'd2,
        PH_HEX2    = 3'd3,
        PH_DONE    = 3'd4
    } phase_t;

    // One input beat.
    typedef struct packed {
        logic [BYTE_W-1:0] line_byte;
        logic              end_of_line;
    } beat_t;

    // Decoded hex digit.
    typedef struct packed {
        logic                valid;
        logic [NIBBLE_W-1:0] value;
    } hex_t;

    // Decodes one ASCII hex digit, either case.
    function automatic hex_t hex_decode(input logic [BYTE_W-1:0] c);
        hex_t              h;
        logic [BYTE_W-1:0] diff;
        h    = '0;
        diff = '0;
        if (c >= CH_0 && c <= CH_9) begin
            diff    = c - CH_0;
            h.valid = 1'b1;
        end else if (c >= CH_UA && c <= CH_UF) begin
            diff    = c - CH_UA + HEX_TEN;
            h.valid = 1'b1;
        end else if (c >= CH_LA && c <= CH_LF) begin
            diff    = c - CH_LA + HEX_TEN;
            h.valid = 1'b1;
        end
        h.value = diff[NIBBLE_W-1:0];
        return h;
    endfunction

endpackage

// File: rtl/core/cfv_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfv_in_reg
// Input register: holds one beat and passes it on when the checker takes it.
// ----------------------------------------------------------------------------
module cfv_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           up_valid,
    output logic           up_ready,
    input  cfv_pkg::beat_t up_beat,
    output logic           dn_valid,
    input  logic           dn_ready,
    output cfv_pkg::beat_t dn_beat
);

    logic           vld_reg;
    logic           vld_next;
    cfv_pkg::beat_t beat_reg;

    // The register can load whenever it is empty or being drained.
    assign up_ready = !vld_reg || dn_ready;

    always_comb begin
        vld_next = vld_reg;
        if (up_ready) begin
            vld_next = up_valid;
        end
    end

    // Valid flag is control state; the beat itself needs no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && up_valid) begin
            beat_reg <= up_beat;
        end
    end

    assign dn_valid = vld_reg;
    assign dn_beat  = beat_reg;

endmodule

// File: rtl/core/cfv_line_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfv_line_chk
// Line checker: tracks the position in the line, accumulates the payload XOR
// and registers the verdict on the final beat.
// ----------------------------------------------------------------------------
module cfv_line_chk (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  cfv_pkg::beat_t             in_beat,
    output logic                       res_valid,
    input  logic                       res_ready,
    output logic                       res_frame_ok,
    output logic [cfv_pkg::BYTE_W-1:0] res_computed_sum
);

    cfv_pkg::phase_t               phase_reg, phase_next, step_phase;
    logic [cfv_pkg::BYTE_W-1:0]    xor_reg, xor_next, step_xor;
    logic [cfv_pkg::NIBBLE_W-1:0]  nib_reg, nib_next, step_nib;
    logic                          seen_reg, seen_next, step_seen;
    logic                          bad_reg, bad_next, step_bad;
    logic                          res_vld_reg, res_vld_next;
    logic                          res_ok_reg;
    logic [cfv_pkg::BYTE_W-1:0]    res_sum_reg;
    logic                          take;
    logic                          eol;
    cfv_pkg::hex_t                 hex;

    // A final beat needs the result slot free or being emptied; other beats
    // leave the result slot alone and always pass.
    assign in_ready = !in_beat.end_of_line || !res_vld_reg || res_ready;
    assign take     = in_valid && in_ready;
    assign eol      = in_beat.end_of_line;
    assign hex      = cfv_pkg::hex_decode(in_beat.line_byte);

    // Next phase.
    always_comb begin
        unique case (phase_reg)
            cfv_pkg::PH_START: begin
                step_phase = cfv_pkg::PH_PAYLOAD;
            end
            cfv_pkg::PH_PAYLOAD: begin
                step_phase = (in_beat.line_byte == cfv_pkg::CH_STAR)
                           ? cfv_pkg::PH_HEX1 : cfv_pkg::PH_PAYLOAD;
            end
            cfv_pkg::PH_HEX1: begin
                step_phase = cfv_pkg::PH_HEX2;
            end
            default: begin
                step_phase = cfv_pkg::PH_DONE;
            end
        endcase
        phase_next = phase_reg;
        if (take) begin
            phase_next = eol ? cfv_pkg::PH_START : step_phase;
        end
    end

    // Datapath update and result for the beat in hand.
    always_comb begin
        step_xor  = xor_reg;
        step_nib  = nib_reg;
        step_seen = seen_reg;
        step_bad  = bad_reg;
        unique case (phase_reg)
            cfv_pkg::PH_START: begin
                if (in_beat.line_byte != cfv_pkg::CH_DOLLAR) begin
                    step_bad = 1'b1;
                end
            end
            cfv_pkg::PH_PAYLOAD: begin
                if (in_beat.line_byte == cfv_pkg::CH_STAR) begin
                    if (!seen_reg) begin
                        step_bad = 1'b1;
                    end
                end else begin
                    step_xor  = xor_reg ^ in_beat.line_byte;
                    step_seen = 1'b1;
                end
            end
            cfv_pkg::PH_HEX1: begin
                if (hex.valid) begin
                    step_nib = hex.value;
                end else begin
                    step_bad = 1'b1;
                end
            end
            cfv_pkg::PH_HEX2: begin
                if (!hex.valid || {nib_reg, hex.value} != xor_reg) begin
                    step_bad = 1'b1;
                end
            end
            default: begin
                // Anything after the second hex digit spoils the line.
                step_bad = 1'b1;
            end
        endcase

        xor_next     = xor_reg;
        nib_next     = nib_reg;
        seen_next    = seen_reg;
        bad_next     = bad_reg;
        res_vld_next = res_vld_reg && !res_ready;
        if (take) begin
            if (eol) begin
                xor_next     = '0;
                nib_next     = '0;
                seen_next    = 1'b0;
                bad_next     = 1'b0;
                res_vld_next = 1'b1;
            end else begin
                xor_next  = step_xor;
                nib_next  = step_nib;
                seen_next = step_seen;
                bad_next  = step_bad;
            end
        end
    end

    // Line state and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= cfv_pkg::PH_START;
            xor_reg     <= '0;
            nib_reg     <= '0;
            seen_reg    <= 1'b0;
            bad_reg     <= 1'b0;
            res_vld_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            xor_reg     <= xor_next;
            nib_reg     <= nib_next;
            seen_reg    <= seen_next;
            bad_reg     <= bad_next;
            res_vld_reg <= res_vld_next;
        end
    end

    // Result payload, loaded on the final beat of a line.
    always_ff @(posedge aclk) begin
        if (take && eol) begin
            res_ok_reg  <= !step_bad && (step_phase == cfv_pkg::PH_DONE);
            res_sum_reg <= step_xor;
        end
    end

    assign res_valid        = res_vld_reg;
    assign res_frame_ok     = res_ok_reg;
    assign res_computed_sum = res_sum_reg;

endmodule

// File: rtl/core/checksum_frame_validator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksum_frame_validator_unit
// Streams a text line one byte per beat and reports whether it is a
// well-formed '$...*hh' frame with a matching XOR checksum.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+------------------------------
//  s_      | in        | s_valid / s_ready  | s_line_byte, s_end_of_line
//  m_      | out       | m_valid / m_ready  | m_frame_ok, m_computed_sum
//
//  One byte is taken every cycle while the result side keeps up; the phase
//  and XOR update is combinational logic between the input register and
//  the result register. The verdict is registered when the checker takes
//  the final beat. Reset is synchronous and returns to the start of a line.
//  While a result waits, bytes of the next line still pass; its final beat
//  stops in the input register and s_ready drops until the result is taken.
//
module checksum_frame_validator_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [cfv_pkg::BYTE_W-1:0] s_line_byte,
    input  logic                       s_end_of_line,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_frame_ok,
    output logic [cfv_pkg::BYTE_W-1:0] m_computed_sum
);

    cfv_pkg::beat_t s_beat;
    cfv_pkg::beat_t in_beat;
    logic           in_vld;
    logic           chk_ready;
    logic           chk_take;

    assign s_beat.line_byte   = s_line_byte;
    assign s_beat.end_of_line = s_end_of_line;

    // Input register.
    cfv_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (s_valid),
        .up_ready (s_ready),
        .up_beat  (s_beat),
        .dn_valid (in_vld),
        .dn_ready (chk_ready),
        .dn_beat  (in_beat)
    );

    // Line checker with result register.
    cfv_line_chk u_line_chk (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (in_vld),
        .in_ready         (chk_ready),
        .in_beat          (in_beat),
        .res_valid        (m_valid),
        .res_ready        (m_ready),
        .res_frame_ok     (m_frame_ok),
        .res_computed_sum (m_computed_sum)
    );

    assign chk_take = in_vld && chk_ready;

    // A result only appears after the checker took a final beat.
    a_result_from_eol: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(chk_take && in_beat.end_of_line))
        else $error("result valid without a final beat");

    // A beat that does not end the line leaves no result behind.
    a_no_result_mid_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (chk_take && !in_beat.end_of_line && !m_valid) |=> !m_valid)
        else $error("result valid after a mid-line beat");

    // An empty input register always accepts.
    a_empty_in_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_vld |-> s_ready)
        else $error("input register empty but not ready");

    // A waiting result keeps its valid and payload.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_frame_ok)
                                   && $stable(m_computed_sum)))
        else $error("waiting result changed");

endmodule

// File: dv/checksum_frame_validator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksum_frame_validator_checker
// Watches both channels of the frame validator. It tracks every accepted
// input beat through its own copy of the line parser, queues the verdict
// that each final beat must produce, and compares each accepted result beat
// field by field with the oldest queued verdict.
// ----------------------------------------------------------------------------
module checksum_frame_validator_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [cfv_pkg::BYTE_W-1:0] s_line_byte,
    input  logic                       s_end_of_line,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic                       m_frame_ok,
    input  logic [cfv_pkg::BYTE_W-1:0] m_computed_sum,
    output int                         error_count,
    output int                         verdicts_pending
);

    typedef struct packed {
        logic                       frame_ok;
        logic [cfv_pkg::BYTE_W-1:0] computed_sum;
    } verdict_t;

    verdict_t verdict_q[$];

    // Parser state of the line in flight.
    cfv_pkg::phase_t              line_phase;
    logic [cfv_pkg::BYTE_W-1:0]   sum_acc;
    logic [cfv_pkg::NIBBLE_W-1:0] upper_nibble;
    logic                         payload_seen;
    logic                         line_bad;

    // Value of an ASCII hex digit in either case; valid is low otherwise.
    function automatic cfv_pkg::hex_t digit_value(input logic [cfv_pkg::BYTE_W-1:0] c);
        cfv_pkg::hex_t d;
        d = '0;
        if (c >= cfv_pkg::CH_0 && c <= cfv_pkg::CH_9) begin
            d.valid = 1'b1;
            d.value = cfv_pkg::NIBBLE_W'(c - cfv_pkg::CH_0);
        end else if (c >= cfv_pkg::CH_UA && c <= cfv_pkg::CH_UF) begin
            d.valid = 1'b1;
            d.value = cfv_pkg::NIBBLE_W'(c - cfv_pkg::CH_UA + cfv_pkg::HEX_TEN);
        end else if (c >= cfv_pkg::CH_LA && c <= cfv_pkg::CH_LF) begin
            d.valid = 1'b1;
            d.value = cfv_pkg::NIBBLE_W'(c - cfv_pkg::CH_LA + cfv_pkg::HEX_TEN);
        end
        return d;
    endfunction

    task automatic clear_line();
        line_phase   = cfv_pkg::PH_START;
        sum_acc      = '0;
        upper_nibble = '0;
        payload_seen = 1'b0;
        line_bad     = 1'b0;
    endtask

    // Advances the parser by one byte and queues the verdict on the last one.
    task automatic track_line_byte(input logic [cfv_pkg::BYTE_W-1:0] b, input logic eol);
        cfv_pkg::hex_t d;
        verdict_t      v;
        d = digit_value(b);
        case (line_phase)
            cfv_pkg::PH_START: begin
                if (b != cfv_pkg::CH_DOLLAR) line_bad = 1'b1;
                line_phase = cfv_pkg::PH_PAYLOAD;
            end
            cfv_pkg::PH_PAYLOAD: begin
                if (b == cfv_pkg::CH_STAR) begin
                    if (!payload_seen) line_bad = 1'b1;
                    line_phase = cfv_pkg::PH_HEX1;
                end else begin
                    sum_acc      = sum_acc ^ b;
                    payload_seen = 1'b1;
                end
            end
            cfv_pkg::PH_HEX1: begin
                if (d.valid) upper_nibble = d.value;
                else line_bad = 1'b1;
                line_phase = cfv_pkg::PH_HEX2;
            end
            cfv_pkg::PH_HEX2: begin
                if (!d.valid || {upper_nibble, d.value} != sum_acc) line_bad = 1'b1;
                line_phase = cfv_pkg::PH_DONE;
            end
            default: begin
                line_bad   = 1'b1;
                line_phase = cfv_pkg::PH_DONE;
            end
        endcase
        if (eol) begin
            v.frame_ok     = !line_bad && line_phase == cfv_pkg::PH_DONE;
            v.computed_sum = sum_acc;
            verdict_q.push_back(v);
            clear_line();
        end
    endtask

    // Compare result beats first; a verdict never leaves in the cycle its
    // final input beat arrives.
    always @(posedge aclk) begin
        verdict_t want;
        if (!aresetn) begin
            clear_line();
            verdict_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("result beat with no verdict pending: frame_ok %0d computed_sum %02h",
                           m_frame_ok, m_computed_sum);
                    error_count++;
                end else begin
                    want = verdict_q.pop_front();
                    if (m_frame_ok !== want.frame_ok) begin
                        $error("frame_ok mismatch: expected %0d, actual %0d",
                               want.frame_ok, m_frame_ok);
                        error_count++;
                    end
                    if (m_computed_sum !== want.computed_sum) begin
                        $error("computed_sum mismatch: expected %02h, actual %02h",
                               want.computed_sum, m_computed_sum);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) track_line_byte(s_line_byte, s_end_of_line);
        end
        verdicts_pending <= verdict_q.size();
    end

endmodule

// File: dv/checksum_frame_validator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksum_frame_validator_unit_test
// Feeds the frame validator with directed lines for the rejection cases but
// a wrong checksum and then with random lines, mostly well-formed frames with random payloads and
// some broken or noisy ones, under bursty input and a stalling result side.
// The checker beside the block predicts and compares; this top gives the
// verdict.
// ----------------------------------------------------------------------------
module checksum_frame_validator_unit_test;

    localparam int BYTE_TARGET = 1850;
    localparam int LONG_HOLD   = 400;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN       = 8;

    logic                       aclk           = 1'b0;
    logic                       aresetn        = 1'b0;
    logic                       s_valid        = 1'b0;
    logic                       s_ready;
    logic [cfv_pkg::BYTE_W-1:0] s_line_byte    = '0;
    logic                       s_end_of_line  = 1'b0;
    logic                       m_valid;
    logic                       m_ready        = 1'b0;
    logic                       m_frame_ok;
    logic [cfv_pkg::BYTE_W-1:0] m_computed_sum;

    int error_count;
    int verdicts_pending;

    logic [cfv_pkg::BYTE_W-1:0] line_buf[$];
    int                         burst_left     = 0;
    int                         bytes_sent     = 0;
    int                         idle_cycles    = 0;
    logic                       long_hold_req  = 1'b0;

    checksum_frame_validator_unit i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_line_byte    (s_line_byte),
        .s_end_of_line  (s_end_of_line),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_ok     (m_frame_ok),
        .m_computed_sum (m_computed_sum)
    );

    checksum_frame_validator_checker i_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_line_byte      (s_line_byte),
        .s_end_of_line    (s_end_of_line),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_ok       (m_frame_ok),
        .m_computed_sum   (m_computed_sum),
        .error_count      (error_count),
        .verdicts_pending (verdicts_pending)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Ends the run when no beat moves on either channel for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Result side: segments of always ready, random stalls and a sparse
    // pattern, plus one long hold-off when the stimulus asks for it.
    initial begin
        int mode;
        int seg;
        int k;
        int c;
        bit hold_done;
        hold_done = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            mode = int'($urandom_range(0, 2));
            seg  = int'($urandom_range(20, 200));
            k    = int'($urandom_range(2, 5));
            for (c = 0; c < seg; c++) begin
                if (long_hold_req && !hold_done) begin
                    hold_done = 1'b1;
                    m_ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge aclk);
                end
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 2) != 0);
                    default: m_ready <= (c % k == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    function automatic logic [cfv_pkg::BYTE_W-1:0] hex_char(
        input logic [cfv_pkg::NIBBLE_W-1:0] n,
        input bit upper);
        if (n < cfv_pkg::HEX_TEN) return cfv_pkg::CH_0 + n;
        return (upper ? cfv_pkg::CH_UA : cfv_pkg::CH_LA) + n - cfv_pkg::HEX_TEN;
    endfunction

    // Sends the line in line_buf, in bursts with random gaps between them.
    task automatic send_line();
        int i;
        int gap;
        for (i = 0; i < line_buf.size(); i++) begin
            if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(60, 150))
                                                         : int'($urandom_range(1, 20));
                gap = int'($urandom_range(0, 6));
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            burst_left--;
            s_valid       <= 1'b1;
            s_line_byte   <= line_buf[i];
            s_end_of_line <= (i == line_buf.size() - 1);
            do @(posedge aclk); while (!s_ready);
            bytes_sent++;
        end
    endtask

    task automatic wait_for_verdicts();
        s_valid <= 1'b0;
        do @(posedge aclk); while (verdicts_pending != 0);
    endtask

    // Builds a frame with a random payload, then most of the time leaves it
    // well-formed and otherwise breaks it in one of the known ways.
    task automatic make_random_line();
        int                         kind;
        int                         plen;
        int                         i;
        logic [cfv_pkg::BYTE_W-1:0] sum;
        logic [cfv_pkg::BYTE_W-1:0] b;
        line_buf.delete();
        line_buf.push_back(cfv_pkg::CH_DOLLAR);
        plen = ($urandom_range(0, 9) == 0) ? int'($urandom_range(13, 40))
                                           : int'($urandom_range(1, 12));
        sum  = '0;
        for (i = 0; i < plen; i++) begin
            do b = 8'($urandom_range(1, 255)); while (b == cfv_pkg::CH_STAR);
            line_buf.push_back(b);
            sum ^= b;
        end
        kind = int'($urandom_range(0, 99));
        // Wrong checksum.
        if (kind >= 55 && kind < 63) sum ^= 8'($urandom_range(1, 255));
        line_buf.push_back(cfv_pkg::CH_STAR);
        line_buf.push_back(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
        line_buf.push_back(hex_char(sum[3:0], 1'($urandom_range(0, 1))));

        if (kind >= 63 && kind < 68) begin
            // Bad start byte.
            do b = 8'($urandom_range(1, 255)); while (b == cfv_pkg::CH_DOLLAR);
            line_buf[0] = b;
        end else if (kind >= 68 && kind < 73) begin
            // No asterisk: payload runs to the end of the line.
            repeat (3) void'(line_buf.pop_back());
        end else if (kind >= 73 && kind < 77) begin
            // Empty payload.
            b = ($urandom_range(0, 1) != 0) ? 8'h00 : 8'($urandom_range(0, 255));
            line_buf = '{cfv_pkg::CH_DOLLAR, cfv_pkg::CH_STAR};
            line_buf.push_back(hex_char(b[7:4], 1'($urandom_range(0, 1))));
            line_buf.push_back(hex_char(b[3:0], 1'($urandom_range(0, 1))));
        end else if (kind >= 77 && kind < 82) begin
            // Non-hex character in one of the digit positions.
            do b = 8'($urandom_range(1, 255));
            while ((b >= cfv_pkg::CH_0 && b <= cfv_pkg::CH_9) ||
                   (b >= cfv_pkg::CH_UA && b <= cfv_pkg::CH_UF) ||
                   (b >= cfv_pkg::CH_LA && b <= cfv_pkg::CH_LF));
            line_buf[line_buf.size() - 1 - $urandom_range(0, 1)] = b;
        end else if (kind >= 82 && kind < 87) begin
            // Line ends before both digits.
            repeat ($urandom_range(1, 2)) void'(line_buf.pop_back());
        end else if (kind >= 87 && kind < 92) begin
            // Trailing bytes after the digits.
            repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(1, 255)));
        end else if (kind >= 92 && kind < 95) begin
            // A second asterisk where a digit should be.
            line_buf[line_buf.size() - 1 - $urandom_range(0, 1)] = cfv_pkg::CH_STAR;
        end else if (kind >= 95) begin
            // Plain noise.
            line_buf.delete();
            repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(1, 255)));
        end
    endtask

    initial begin
        int lines;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed lines: valid frames with upper- and lower-case digits and an 0xFF
        // payload byte, then a bad start, an empty payload, no asterisk, a non-hex digit and a trailing byte.
        line_buf = '{cfv_pkg::CH_DOLLAR, 8'hFF, cfv_pkg::CH_STAR, "F", "F"};
        send_line();
        line_buf = '{cfv_pkg::CH_DOLLAR, "z", cfv_pkg::CH_STAR, "7", "a"};
        send_line();
        line_buf = '{cfv_pkg::CH_STAR};
        send_line();
        line_buf = '{cfv_pkg::CH_DOLLAR, cfv_pkg::CH_STAR, "0", "0"};
        send_line();
        line_buf = '{cfv_pkg::CH_DOLLAR, 8'h01};
        send_line();
        line_buf = '{cfv_pkg::CH_DOLLAR, "a", cfv_pkg::CH_STAR, "G"};
        send_line();
        line_buf = '{cfv_pkg::CH_DOLLAR, "a", cfv_pkg::CH_STAR, "6", "1", cfv_pkg::CH_STAR};
        send_line();
        wait_for_verdicts();

        // Random lines, with one long result stall early on and periodic
        // pauses that let every verdict drain.
        lines = 0;
        while (bytes_sent < BYTE_TARGET) begin
            make_random_line();
            send_line();
            lines++;
            if (lines == 30) long_hold_req <= 1'b1;
            if (lines % 60 == 0) wait_for_verdicts();
        end

        wait_for_verdicts();
        repeat (DRAIN) @(posedge aclk);
        @(negedge aclk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
